[rtl/cgr_pkg.sv]
// Package for the colour gradient ramp: item layouts, operation and status codes,
// and the structs that run between the sequencer, the blend unit and the top level.
// No dependencies.
package cgr_pkg;

  // Operation codes carried in the operation field of an input item
  typedef enum logic [2:0] {
    OP_QUERY    = 3'd0,
    OP_ADD      = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_MOVE     = 3'd3,
    OP_RECOLOUR = 3'd4
  } op_t;

  // Status codes returned with every result item
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  // Colour layout: red 7:0, green 15:8, blue 23:16, alpha 31:24
  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [31:0] OPAQUE_WHITE = 32'hFFFF_FFFF;
  localparam logic [15:0] POS_ZERO     = 16'h0000;
  localparam logic [15:0] POS_ONE      = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] position;
    logic [3:0]  mark_index;
    logic [7:0]  query_level;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [4:0] stop_count;
    logic [1:0] status;
  } out_item_t;

  // One entry of the stop table
  typedef struct packed {
    logic [15:0] pos;
    logic [31:0] col;
  } stop_entry_t;

  typedef struct packed {
    logic     start;
    in_item_t item;
  } seq_req_t;

  typedef struct packed {
    logic      idle;
    logic      done;
    out_item_t item;
  } seq_rsp_t;

  typedef struct packed {
    logic        start;
    logic [7:0]  cl;
    logic [7:0]  cu;
    logic [15:0] t;
    logic [15:0] d;
  } lerp_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] q;
  } lerp_rsp_t;

  typedef enum logic [4:0] {
    S_INIT0,
    S_INIT1,
    S_IDLE,
    S_Q_SCAN,
    S_Q_LERP,
    S_Q_WAIT,
    S_I_START,
    S_I_SHIFT,
    S_I_LAST,
    S_D_START,
    S_D_SHIFT,
    S_M_READ,
    S_R_READ,
    S_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL_LO,
    L_MUL_HI,
    L_DIV,
    L_FIN
  } lerp_state_t;

endpackage

[rtl/cgr_chan_if.sv]
// Valid/ready channel carrying one item of a given payload type.
// Depends on nothing; payload types come from cgr_pkg at the point of use.
interface cgr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/cgr_lerp_unit.sv]
// Shared blend unit: one channel of floor((cl*(d-t) + cu*t) / d) per request.
// One 8x16 multiplier used twice, then a restoring divider at one bit a cycle.
// Depends on cgr_pkg.
module cgr_lerp_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  cgr_pkg::lerp_req_t   req,
  output cgr_pkg::lerp_rsp_t   rsp
);

  cgr_pkg::lerp_state_t state, state_next;

  logic [7:0]  cl, cl_next;
  logic [7:0]  cu, cu_next;
  logic [15:0] t, t_next;
  logic [15:0] d, d_next;
  logic [15:0] dmt, dmt_next;
  logic [23:0] acc, acc_next;
  logic [23:0] dsh, dsh_next;
  logic [7:0]  quo, quo_next;
  logic [2:0]  step, step_next;

  logic [7:0]  mul_a;
  logic [15:0] mul_b;
  logic [23:0] prod;
  logic [24:0] diff;
  logic        ge;

  assign mul_a = (state == cgr_pkg::L_MUL_LO) ? cl : cu;
  assign mul_b = (state == cgr_pkg::L_MUL_LO) ? dmt : t;
  assign prod  = {16'b0, mul_a} * {8'b0, mul_b};
  assign diff  = {1'b0, acc} - {1'b0, dsh};
  assign ge    = !diff[24];

  always_comb begin
    state_next = state;
    cl_next    = cl;
    cu_next    = cu;
    t_next     = t;
    d_next     = d;
    dmt_next   = dmt;
    acc_next   = acc;
    dsh_next   = dsh;
    quo_next   = quo;
    step_next  = step;
    case (state)
      cgr_pkg::L_IDLE: begin
        if (req.start) begin
          cl_next    = req.cl;
          cu_next    = req.cu;
          t_next     = req.t;
          d_next     = req.d;
          dmt_next   = req.d - req.t;
          state_next = cgr_pkg::L_MUL_LO;
        end
      end
      cgr_pkg::L_MUL_LO: begin
        acc_next   = prod;
        state_next = cgr_pkg::L_MUL_HI;
      end
      cgr_pkg::L_MUL_HI: begin
        acc_next   = acc + prod;
        dsh_next   = {1'b0, d, 7'b0};
        quo_next   = 8'd0;
        step_next  = 3'd7;
        state_next = cgr_pkg::L_DIV;
      end
      cgr_pkg::L_DIV: begin
        if (ge) begin
          acc_next = diff[23:0];
        end
        quo_next  = {quo[6:0], ge};
        dsh_next  = dsh >> 1;
        step_next = step - 3'd1;
        if (step == 3'd0) begin
          state_next = cgr_pkg::L_FIN;
        end
      end
      cgr_pkg::L_FIN: begin
        state_next = cgr_pkg::L_IDLE;
      end
      default: begin
        state_next = cgr_pkg::L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgr_pkg::L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cl   <= cl_next;
    cu   <= cu_next;
    t    <= t_next;
    d    <= d_next;
    dmt  <= dmt_next;
    acc  <= acc_next;
    dsh  <= dsh_next;
    quo  <= quo_next;
    step <= step_next;
  end

  assign rsp.done = (state == cgr_pkg::L_FIN);
  assign rsp.q    = quo;

  // Restoring division keeps the remainder below twice the shifted divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == cgr_pkg::L_DIV |-> {1'b0, acc} < {dsh, 1'b0})
    else $error("blend remainder out of range");

endmodule

[rtl/cgr_stop_seq.sv]
// Stop table sequencer: holds the sorted stop memory and the stop count, and
// walks the table one entry a cycle for queries, inserts, removals and moves.
// Depends on cgr_pkg and drives the shared blend unit cgr_lerp_unit.
module cgr_stop_seq #(
  parameter int MAX_STOPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cgr_pkg::seq_req_t  req,
  input  logic               hold,
  output cgr_pkg::seq_rsp_t  rsp,
  output cgr_pkg::lerp_req_t lerp_req,
  input  cgr_pkg::lerp_rsp_t lerp_rsp
);

  localparam int AW   = $clog2(MAX_STOPS);
  localparam int CW   = $clog2(MAX_STOPS + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  cgr_pkg::seq_state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] k, k_next;
  logic [1:0]    ch, ch_next;
  logic [2:0]    op, op_next;
  logic [15:0]   new_pos, new_pos_next;
  logic [3:0]    idx, idx_next;
  logic [15:0]   p, p_next;
  logic [31:0]   new_col, new_col_next;
  logic [15:0]   d, d_next;
  logic [15:0]   t, t_next;
  logic [31:0]   col_lo, col_lo_next;
  logic [31:0]   col_hi, col_hi_next;
  logic [31:0]   res_col, res_col_next;
  cgr_pkg::stop_entry_t prev, prev_next;
  cgr_pkg::status_t     status, status_next;

  cgr_pkg::stop_entry_t mem [MAX_STOPS];
  cgr_pkg::stop_entry_t rd_data;
  cgr_pkg::stop_entry_t wr_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 we;

  logic present;
  logic full;

  assign present = CMPW'(req.item.mark_index) < CMPW'(count);
  assign full    = (count == CW'(MAX_STOPS));

  always_comb begin
    state_next   = state;
    count_next   = count;
    k_next       = k;
    ch_next      = ch;
    op_next      = op;
    new_pos_next = new_pos;
    idx_next     = idx;
    p_next       = p;
    new_col_next = new_col;
    d_next       = d;
    t_next       = t;
    col_lo_next  = col_lo;
    col_hi_next  = col_hi;
    res_col_next = res_col;
    prev_next    = prev;
    status_next  = status;
    rd_addr      = '0;
    wr_addr      = '0;
    wr_data      = rd_data;
    we           = 1'b0;
    lerp_req.start = 1'b0;
    lerp_req.cl    = col_lo[{ch, 3'b000} +: 8];
    lerp_req.cu    = col_hi[{ch, 3'b000} +: 8];
    lerp_req.t     = t;
    lerp_req.d     = d;

    case (state)
      cgr_pkg::S_INIT0: begin
        we         = 1'b1;
        wr_addr    = '0;
        wr_data    = '{pos: cgr_pkg::POS_ZERO, col: cgr_pkg::OPAQUE_BLACK};
        state_next = cgr_pkg::S_INIT1;
      end
      cgr_pkg::S_INIT1: begin
        we         = 1'b1;
        wr_addr    = AW'(1);
        wr_data    = '{pos: cgr_pkg::POS_ONE, col: cgr_pkg::OPAQUE_WHITE};
        state_next = cgr_pkg::S_IDLE;
      end
      cgr_pkg::S_IDLE: begin
        if (req.start) begin
          op_next      = req.item.operation;
          new_pos_next = req.item.position;
          idx_next     = req.item.mark_index;
          p_next       = {req.item.query_level, req.item.query_level};
          new_col_next = {req.item.alpha_in, req.item.blue_in,
                          req.item.green_in, req.item.red_in};
          res_col_next = '0;
          status_next  = cgr_pkg::ST_OK;
          k_next       = '0;
          rd_addr      = AW'(req.item.mark_index);
          state_next   = cgr_pkg::S_DONE;
          case (req.item.operation)
            cgr_pkg::OP_QUERY: begin
              rd_addr = '0;
              if (count == '0) begin
                res_col_next = cgr_pkg::OPAQUE_BLACK;
              end else begin
                state_next = cgr_pkg::S_Q_SCAN;
              end
            end
            cgr_pkg::OP_ADD: begin
              if (full) begin
                status_next = cgr_pkg::ST_FULL;
              end else begin
                state_next = cgr_pkg::S_I_START;
              end
            end
            cgr_pkg::OP_REMOVE: begin
              if (!present) begin
                status_next = cgr_pkg::ST_ABSENT;
              end else begin
                state_next = cgr_pkg::S_D_START;
              end
            end
            cgr_pkg::OP_MOVE: begin
              if (!present) begin
                status_next = cgr_pkg::ST_ABSENT;
              end else begin
                state_next = cgr_pkg::S_M_READ;
              end
            end
            cgr_pkg::OP_RECOLOUR: begin
              if (!present) begin
                status_next = cgr_pkg::ST_ABSENT;
              end else begin
                state_next = cgr_pkg::S_R_READ;
              end
            end
            default: begin
              state_next = cgr_pkg::S_DONE;
            end
          endcase
        end
      end
      cgr_pkg::S_Q_SCAN: begin
        rd_addr = AW'(k + CW'(1));
        if (rd_data.pos > p) begin
          if (k == '0) begin
            res_col_next = rd_data.col;
            state_next   = cgr_pkg::S_DONE;
          end else begin
            d_next      = rd_data.pos - prev.pos;
            t_next      = p - prev.pos;
            col_lo_next = prev.col;
            col_hi_next = rd_data.col;
            ch_next     = '0;
            state_next  = cgr_pkg::S_Q_LERP;
          end
        end else begin
          prev_next = rd_data;
          if (k + CW'(1) == count) begin
            res_col_next = rd_data.col;
            state_next   = cgr_pkg::S_DONE;
          end else begin
            k_next = k + CW'(1);
          end
        end
      end
      cgr_pkg::S_Q_LERP: begin
        lerp_req.start = 1'b1;
        state_next     = cgr_pkg::S_Q_WAIT;
      end
      cgr_pkg::S_Q_WAIT: begin
        if (lerp_rsp.done) begin
          res_col_next[{ch, 3'b000} +: 8] = lerp_rsp.q;
          if (ch == 2'd3) begin
            state_next = cgr_pkg::S_DONE;
          end else begin
            ch_next    = ch + 2'd1;
            state_next = cgr_pkg::S_Q_LERP;
          end
        end
      end
      cgr_pkg::S_I_START: begin
        if (count == '0) begin
          we         = 1'b1;
          wr_addr    = '0;
          wr_data    = '{pos: new_pos, col: new_col};
          count_next = count + CW'(1);
          state_next = cgr_pkg::S_DONE;
        end else begin
          k_next     = count - CW'(1);
          rd_addr    = AW'(count - CW'(1));
          state_next = cgr_pkg::S_I_SHIFT;
        end
      end
      cgr_pkg::S_I_SHIFT: begin
        we      = 1'b1;
        wr_addr = AW'(k + CW'(1));
        if (rd_data.pos > new_pos) begin
          // shift this entry up and keep looking lower
          wr_data = rd_data;
          if (k == '0) begin
            state_next = cgr_pkg::S_I_LAST;
          end else begin
            k_next  = k - CW'(1);
            rd_addr = AW'(k - CW'(1));
          end
        end else begin
          wr_data    = '{pos: new_pos, col: new_col};
          count_next = count + CW'(1);
          state_next = cgr_pkg::S_DONE;
        end
      end
      cgr_pkg::S_I_LAST: begin
        we         = 1'b1;
        wr_addr    = '0;
        wr_data    = '{pos: new_pos, col: new_col};
        count_next = count + CW'(1);
        state_next = cgr_pkg::S_DONE;
      end
      cgr_pkg::S_D_START: begin
        k_next  = CW'(idx);
        rd_addr = AW'(CMPW'(idx) + CMPW'(1));
        if (CMPW'(idx) + CMPW'(1) >= CMPW'(count)) begin
          count_next = count - CW'(1);
          state_next = (op == cgr_pkg::OP_MOVE) ? cgr_pkg::S_I_START : cgr_pkg::S_DONE;
        end else begin
          state_next = cgr_pkg::S_D_SHIFT;
        end
      end
      cgr_pkg::S_D_SHIFT: begin
        we      = 1'b1;
        wr_addr = AW'(k);
        wr_data = rd_data;
        rd_addr = AW'(k + CW'(2));
        if (k + CW'(2) >= count) begin
          count_next = count - CW'(1);
          state_next = (op == cgr_pkg::OP_MOVE) ? cgr_pkg::S_I_START : cgr_pkg::S_DONE;
        end else begin
          k_next = k + CW'(1);
        end
      end
      cgr_pkg::S_M_READ: begin
        new_col_next = rd_data.col;
        state_next   = cgr_pkg::S_D_START;
      end
      cgr_pkg::S_R_READ: begin
        we         = 1'b1;
        wr_addr    = AW'(idx);
        wr_data    = '{pos: rd_data.pos, col: new_col};
        state_next = cgr_pkg::S_DONE;
      end
      cgr_pkg::S_DONE: begin
        if (!hold) begin
          state_next = cgr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cgr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgr_pkg::S_INIT0;
      count <= CW'(2);
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    k       <= k_next;
    ch      <= ch_next;
    op      <= op_next;
    new_pos <= new_pos_next;
    idx     <= idx_next;
    p       <= p_next;
    new_col <= new_col_next;
    d       <= d_next;
    t       <= t_next;
    col_lo  <= col_lo_next;
    col_hi  <= col_hi_next;
    res_col <= res_col_next;
    prev    <= prev_next;
    status  <= status_next;
  end

  // Stop memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign rsp.idle            = (state == cgr_pkg::S_IDLE);
  assign rsp.done            = (state == cgr_pkg::S_DONE) && !hold;
  assign rsp.item.red_out    = res_col[7:0];
  assign rsp.item.green_out  = res_col[15:8];
  assign rsp.item.blue_out   = res_col[23:16];
  assign rsp.item.alpha_out  = res_col[31:24];
  assign rsp.item.stop_count = 5'(count);
  assign rsp.item.status     = status;

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_STOPS))
    else $error("stop count above table size");

  a_write_span: assert property (@(posedge clk) disable iff (rst)
    we |-> CW'(wr_addr) <= count)
    else $error("table write beyond held stops");

  a_scan_span: assert property (@(posedge clk) disable iff (rst)
    state == cgr_pkg::S_Q_SCAN |-> k < count)
    else $error("query scan past last held stop");

endmodule

[rtl/color_gradient_ramp_core.sv]
// Top level of the colour gradient ramp: valid/ready item channels, result register,
// stop table sequencer and shared blend unit.
// Depends on cgr_pkg, cgr_chan_if, cgr_stop_seq and cgr_lerp_unit.
//
//   channel    modport  payload               carries
//   request    sink     cgr_pkg::in_item_t    one operation on the stop table
//   response   source   cgr_pkg::out_item_t   colour, stop count and status
//
// Sequencing: an item is taken only while the sequencer is idle and runs to
// completion before the next is taken. A query scans the table one stop a cycle
// through the memory's read port, then takes the four channels in turn through the
// shared blend unit (two multiply steps, eight divide steps); an end-colour query
// skips the blend. An add shifts the stops above its position up, a remove shifts
// those above the index down, a move removes then re-adds its stop, a recolour rewrites one.
// Reset: synchronous; after rst falls the table loads the two default stops
// (black at 0, white at 1.0) in its init states before request.ready rises.
// Stalls: a finished result waits in the response register; a new request is taken
// meanwhile, and its result is held back in the sequencer until that register frees.
module color_gradient_ramp_core #(
  parameter int MAX_STOPS = 16
) (
  input logic        clk,
  input logic        rst,
  cgr_chan_if.sink   request,
  cgr_chan_if.source response
);

  cgr_pkg::seq_req_t  seq_req;
  cgr_pkg::seq_rsp_t  seq_rsp;
  cgr_pkg::lerp_req_t lerp_req;
  cgr_pkg::lerp_rsp_t lerp_rsp;

  logic               out_valid;
  cgr_pkg::out_item_t out_item;
  logic               hold;

  // Take a new item only while the sequencer sits idle
  assign request.ready = seq_rsp.idle;
  assign seq_req.start = request.valid && request.ready;
  assign seq_req.item  = request.payload;

  // Hold the sequencer's result while the response register is still occupied
  assign hold = out_valid && !response.ready;

  cgr_stop_seq #(
    .MAX_STOPS (MAX_STOPS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (seq_req),
    .hold     (hold),
    .rsp      (seq_rsp),
    .lerp_req (lerp_req),
    .lerp_rsp (lerp_rsp)
  );

  cgr_lerp_unit u_lerp (
    .clk (clk),
    .rst (rst),
    .req (lerp_req),
    .rsp (lerp_rsp)
  );

  // Response register: load on a finished item, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_rsp.done) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_rsp.done) begin
      out_item <= seq_rsp.item;
    end
  end

  assign response.valid   = out_valid;
  assign response.payload = out_item;

  // A result must never land on top of one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    seq_rsp.done |-> !(out_valid && !response.ready))
    else $error("result overwrote a pending item");

endmodule
